@@ hw/rtl/gec_pkg.sv @@
// ----------------------------------------------------------------------------
// gec_pkg
// Shared constants, register codes and weight helpers for the edge cost block.
// ----------------------------------------------------------------------------
package gec_pkg;

  // Value fields and weights.
  localparam int VAL_W  = 16;          // Q4.12 curvature and sulcal height
  localparam int SHV_W  = VAL_W + 1;   // shifted value, signed
  localparam int WGT_W  = 16;          // Q8.8 weights and penalties
  localparam int FAC_W  = 32;          // weight factor (penalty part)
  localparam int QB     = 17;          // bits of one unit vector component
  localparam int UNIT_SH = 22;         // pre-shift of the divider dividend
  localparam int NTERM  = 8;

  localparam logic [FAC_W-1:0] F_UNIT = 32'h0001_0000;
  localparam logic [63:0] TERM_CAP = 64'h2000_0000_0000_0000;

  // Register codes, one per 8-byte slot.
  localparam logic [2:0] REG_RANGE  = 3'd0;
  localparam logic [2:0] REG_SWGT   = 3'd1;
  localparam logic [2:0] REG_PWGT   = 3'd2;
  localparam logic [2:0] REG_PEN1   = 3'd3;
  localparam logic [2:0] REG_PEN2   = 3'd4;
  localparam logic [2:0] REG_GOAL_X = 3'd5;
  localparam logic [2:0] REG_GOAL_Y = 3'd6;
  localparam logic [2:0] REG_GOAL_Z = 3'd7;

  localparam logic [31:0] RST_RANGE = 32'h0000_0000;
  localparam logic [63:0] RST_SWGT  = 64'h0100_0100_0100_0100;
  localparam logic [63:0] RST_PWGT  = 64'h0100_0100_0100_0100;
  localparam logic [63:0] RST_PEN1  = 64'h0A00_0A00_0A00_0A00;
  localparam logic [31:0] RST_PEN2  = 32'h0100_0A00;

  // Term order, which is also the accumulation order.
  localparam int T_DIST = 0;
  localparam int T_CURV = 1;
  localparam int T_SULC = 2;
  localparam int T_DS   = 3;
  localparam int T_DC   = 4;
  localparam int T_CS   = 5;
  localparam int T_DCS  = 6;
  localparam int T_DIR  = 7;

  localparam int TERM_SHIFT [0:NTERM-1] = '{24, 20, 20, 36, 36, 32, 36, 24};

  // Factor that multiplies a weight when one value may be negative.
  function automatic logic [FAC_W-1:0] wgt_one(input logic neg, input logic [WGT_W-1:0] p);
    wgt_one = neg ? {8'b0, p, 8'b0} : F_UNIT;
  endfunction

  // Factor for the cross terms; pp is the penalty squared.
  function automatic logic [FAC_W-1:0] wgt_two(input logic n1, input logic n2,
                                               input logic [WGT_W-1:0] p,
                                               input logic [FAC_W-1:0] pp);
    wgt_two = (n1 && n2) ? pp : wgt_one(n1 || n2, p);
  endfunction

endpackage

@@ hw/rtl/geodesic_edge_cost_top.sv @@
// ----------------------------------------------------------------------------
// geodesic_edge_cost_top
// Pipelined fixed-point cost of one mesh edge for a guided geodesic search.
// ----------------------------------------------------------------------------
// Each item on the input channel (item_valid / item_ready) carries the two end
// points of one edge plus the curvature and sulcal height at the far vertex.
// Each item yields exactly one edge_cost item on the output channel
// (cost_valid / cost_ready), in input order.
// The block is one deep pipeline: a square-root unit that settles one root bit
// per stage, a restoring divider that settles one quotient bit per stage, then
// products, split weight multiplies and an eight-stage saturating accumulator.
// An item enters in every cycle in which item_ready is high. The square-root
// stages, COORD_WIDTH + 7 of them, are the longest part of the pipeline.
// When the receiver stalls, the output register holds its item and the
// pipeline keeps moving until its last stage is full; then the whole pipeline
// freezes and item_ready drops. Nothing is lost or repeated.
// Synchronous reset clears all valid bits and loads register defaults (unit
// weights, penalties of ten but a DCS cross penalty of one, goal at origin).
// The 64-bit APB-style configuration port has registers at 8-byte steps;
// the user writes it only while no item is in flight; the block does not check.
// ----------------------------------------------------------------------------
module geodesic_edge_cost_top
  import gec_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COST_WIDTH  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [COORD_WIDTH-1:0] from_x,
  input  logic signed [COORD_WIDTH-1:0] from_y,
  input  logic signed [COORD_WIDTH-1:0] from_z,
  input  logic signed [COORD_WIDTH-1:0] to_x,
  input  logic signed [COORD_WIDTH-1:0] to_y,
  input  logic signed [COORD_WIDTH-1:0] to_z,
  input  logic signed [VAL_W-1:0]       curv_value,
  input  logic signed [VAL_W-1:0]       sulc_value,
  output logic                          cost_valid,
  input  logic                          cost_ready,
  output logic [COST_WIDTH-1:0]         edge_cost
);

  localparam int W     = COORD_WIDTH;
  localparam int RB    = W + 7;          // root bits of the unit-vector norm
  localparam int RW    = 2 * RB;         // radicand width
  localparam int SSW   = 2 * W + 2;      // sum of three squares
  localparam int DDW   = W + UNIT_SH;    // divider remainder
  localparam int DCW   = DDW + 1;        // divider compare width
  localparam int DISTW = RB - 4;         // edge length, Q.16
  localparam int DCMW  = DISTW + SHV_W;  // dist * shifted value
  localparam int CSW   = 2 * SHV_W;
  localparam int XW    = DCMW + SHV_W - 12;
  localparam int AW    = XW + WGT_W;
  localparam int PW    = AW + 16;
  localparam int BW    = AW + FAC_W;
  localparam int NACC  = NTERM;
  localparam logic [63:0] COST_MAX = {64{1'b1}} >> (64 - COST_WIDTH);

  typedef struct packed {
    logic [2:0][W-1:0]  em;
    logic [2:0]         es;
    logic [2:0][W-1:0]  gm;
    logic [2:0]         gs;
    logic [SHV_W-1:0]   cm;
    logic               csg;
    logic [SHV_W-1:0]   sm;
    logic               ssg;
    logic               cneg;
    logic               sneg;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [31:0]         range_maxima;
  logic [63:0]         single_weights;
  logic [63:0]         pair_weights;
  logic [63:0]         penalties_first;
  logic [31:0]         penalties_second;
  logic signed [W-1:0] goal_x;
  logic signed [W-1:0] goal_y;
  logic signed [W-1:0] goal_z;
  logic [FAC_W-1:0]    pp_cs;
  logic [FAC_W-1:0]    pp_dcs;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_maxima     <= RST_RANGE;
      single_weights   <= RST_SWGT;
      pair_weights     <= RST_PWGT;
      penalties_first  <= RST_PEN1;
      penalties_second <= RST_PEN2;
      goal_x           <= '0;
      goal_y           <= '0;
      goal_z           <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_RANGE:  range_maxima     <= pwdata[31:0];
        REG_SWGT:   single_weights   <= pwdata;
        REG_PWGT:   pair_weights     <= pwdata;
        REG_PEN1:   penalties_first  <= pwdata;
        REG_PEN2:   penalties_second <= pwdata[31:0];
        REG_GOAL_X: goal_x           <= pwdata[W-1:0];
        REG_GOAL_Y: goal_y           <= pwdata[W-1:0];
        REG_GOAL_Z: goal_z           <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_RANGE:  prdata = {32'b0, range_maxima};
      REG_SWGT:   prdata = single_weights;
      REG_PWGT:   prdata = pair_weights;
      REG_PEN1:   prdata = penalties_first;
      REG_PEN2:   prdata = {32'b0, penalties_second};
      REG_GOAL_X: prdata = {{(64-W){1'b0}}, goal_x};
      REG_GOAL_Y: prdata = {{(64-W){1'b0}}, goal_y};
      REG_GOAL_Z: prdata = {{(64-W){1'b0}}, goal_z};
      default:    prdata = '0;
    endcase
  end

  // Squared penalties for the cross terms; registers settle long before any
  // item reaches the weight stage.
  always_ff @(posedge clk) begin
    pp_cs  <= FAC_W'(penalties_second[15:0]) * FAC_W'(penalties_second[15:0]);
    pp_dcs <= FAC_W'(penalties_second[31:16]) * FAC_W'(penalties_second[31:16]);
  end

  // --------------------------------------------------------------------------
  // Pipeline control. The last accumulator stage may always fill if empty.
  // --------------------------------------------------------------------------
  logic            en;
  logic            s0_v;
  logic            s1_v;
  logic [RB:0]     sq_v;
  logic [QB:1]     dv_v;
  logic            p1_v;
  logic            p2_v;
  logic            p3_v;
  logic            ta_v;
  logic            tb_v;
  logic            tc_v;
  logic            td_v;
  logic [NACC-1:0] ac_v;

  assign en         = !ac_v[NACC-1] || !cost_valid || cost_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      sq_v <= '0;
      dv_v <= '0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      ta_v <= 1'b0;
      tb_v <= 1'b0;
      tc_v <= 1'b0;
      td_v <= 1'b0;
      ac_v <= '0;
    end else if (en) begin
      s0_v <= item_valid;
      s1_v <= s0_v;
      sq_v <= {sq_v[RB-1:0], s1_v};
      dv_v <= {dv_v[QB-1:1], sq_v[RB]};
      p1_v <= dv_v[QB];
      p2_v <= p1_v;
      p3_v <= p2_v;
      ta_v <= p3_v;
      tb_v <= ta_v;
      tc_v <= tb_v;
      td_v <= tc_v;
      ac_v <= {ac_v[NACC-2:0], td_v};
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: edge and goal vectors as magnitude and sign, shifted values.
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0] from_v;
  logic [2:0][W-1:0] to_v;
  logic [2:0][W-1:0] goal_v;
  side_t             side_in;
  side_t             s0_side;

  assign from_v = {from_z, from_y, from_x};
  assign to_v   = {to_z, to_y, to_x};
  assign goal_v = {goal_z, goal_y, goal_x};

  always_comb begin
    logic signed [W:0]       ed;
    logic signed [W:0]       gd;
    logic signed [SHV_W-1:0] cv;
    logic signed [SHV_W-1:0] sv;
    side_in = '0;
    for (int i = 0; i < 3; i++) begin
      ed = $signed({to_v[i][W-1], to_v[i]}) - $signed({from_v[i][W-1], from_v[i]});
      gd = $signed({goal_v[i][W-1], goal_v[i]}) - $signed({from_v[i][W-1], from_v[i]});
      side_in.em[i] = ed[W] ? W'(-ed) : W'(ed);
      side_in.es[i] = ed[W];
      side_in.gm[i] = gd[W] ? W'(-gd) : W'(gd);
      side_in.gs[i] = gd[W];
    end
    cv = $signed({range_maxima[15], range_maxima[15:0]})
       - $signed({curv_value[VAL_W-1], curv_value});
    sv = $signed({range_maxima[31], range_maxima[31:16]})
       - $signed({sulc_value[VAL_W-1], sulc_value});
    side_in.cm   = cv[SHV_W-1] ? -cv : cv;
    side_in.csg  = cv[SHV_W-1];
    side_in.sm   = sv[SHV_W-1] ? -sv : sv;
    side_in.ssg  = sv[SHV_W-1];
    side_in.cneg = curv_value[VAL_W-1];
    side_in.sneg = sulc_value[VAL_W-1];
  end

  // --------------------------------------------------------------------------
  // Squares, then radicands scaled by 2^12 for the norm.
  // --------------------------------------------------------------------------
  logic [2:0][2*W-1:0] s1_esq;
  logic [2:0][2*W-1:0] s1_gsq;
  side_t               s1_side;
  logic [RW-1:0]       sq_ope [0:RB];
  logic [RW-1:0]       sq_rese [0:RB];
  logic [RW-1:0]       sq_opg [0:RB];
  logic [RW-1:0]       sq_resg [0:RB];
  side_t               sq_side [0:RB];

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= side_in;
      for (int i = 0; i < 3; i++) begin
        s1_esq[i] <= (2*W)'(s0_side.em[i]) * (2*W)'(s0_side.em[i]);
        s1_gsq[i] <= (2*W)'(s0_side.gm[i]) * (2*W)'(s0_side.gm[i]);
      end
      s1_side    <= s0_side;
      sq_ope[0]  <= {SSW'(s1_esq[0]) + SSW'(s1_esq[1]) + SSW'(s1_esq[2]), 12'b0};
      sq_opg[0]  <= {SSW'(s1_gsq[0]) + SSW'(s1_gsq[1]) + SSW'(s1_gsq[2]), 12'b0};
      sq_rese[0] <= '0;
      sq_resg[0] <= '0;
      sq_side[0] <= s1_side;
    end
  end

  // Square root, one root bit per stage, for the edge and goal vectors.
  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int SH = 2 * (RB - 1 - k);
    logic [RW:0] te;
    logic [RW:0] tg;
    assign te = {1'b0, sq_rese[k]} + ((RW+1)'(1) << SH);
    assign tg = {1'b0, sq_resg[k]} + ((RW+1)'(1) << SH);
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, sq_ope[k]} >= te) begin
          sq_ope[k+1]  <= sq_ope[k] - te[RW-1:0];
          sq_rese[k+1] <= (sq_rese[k] >> 1) + (RW'(1) << SH);
        end else begin
          sq_ope[k+1]  <= sq_ope[k];
          sq_rese[k+1] <= sq_rese[k] >> 1;
        end
        if ({1'b0, sq_opg[k]} >= tg) begin
          sq_opg[k+1]  <= sq_opg[k] - tg[RW-1:0];
          sq_resg[k+1] <= (sq_resg[k] >> 1) + (RW'(1) << SH);
        end else begin
          sq_opg[k+1]  <= sq_opg[k];
          sq_resg[k+1] <= sq_resg[k] >> 1;
        end
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: six unit vector components, one quotient bit a stage.
  // --------------------------------------------------------------------------
  logic [DDW-1:0] dv_rem [1:QB][0:5];
  logic [QB-1:0]  dv_q   [1:QB][0:5];
  logic [RB-1:0]  dv_ne  [1:QB];
  logic [RB-1:0]  dv_ng  [1:QB];
  side_t          dv_side [1:QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic [DDW-1:0] rin [0:5];
    logic [QB-1:0]  qin [0:5];
    logic [RB-1:0]  nein;
    logic [RB-1:0]  ngin;
    side_t          sin;
    if (k == 0) begin : g_first
      assign nein = sq_rese[RB][RB-1:0];
      assign ngin = sq_resg[RB][RB-1:0];
      assign sin  = sq_side[RB];
      for (genvar i = 0; i < 3; i++) begin : g_load
        assign rin[i]   = {sq_side[RB].em[i], {UNIT_SH{1'b0}}};
        assign rin[i+3] = {sq_side[RB].gm[i], {UNIT_SH{1'b0}}};
      end
      for (genvar i = 0; i < 6; i++) begin : g_qz
        assign qin[i] = '0;
      end
    end else begin : g_next
      assign nein = dv_ne[k];
      assign ngin = dv_ng[k];
      assign sin  = dv_side[k];
      for (genvar i = 0; i < 6; i++) begin : g_pass
        assign rin[i] = dv_rem[k][i];
        assign qin[i] = dv_q[k][i];
      end
    end
    for (genvar i = 0; i < 6; i++) begin : g_comp
      logic [DCW-1:0] dsh;
      assign dsh = DCW'(i < 3 ? nein : ngin) << B;
      always_ff @(posedge clk) begin
        if (en) begin
          if ({1'b0, rin[i]} >= dsh) begin
            dv_rem[k+1][i] <= rin[i] - dsh[DDW-1:0];
            dv_q[k+1][i]   <= qin[i] | (QB'(1) << B);
          end else begin
            dv_rem[k+1][i] <= rin[i];
            dv_q[k+1][i]   <= qin[i];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_ne[k+1]   <= nein;
        dv_ng[k+1]   <= ngin;
        dv_side[k+1] <= sin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Dot product, direction term and the distance products.
  // --------------------------------------------------------------------------
  logic signed [35:0]  p1_prod [0:2];
  logic [DISTW-1:0]    p1_dist;
  side_t               p1_side;
  logic [19:0]         p2_dir;
  logic [DISTW-1:0]    p2_dist;
  logic [DCMW-1:0]     p2_dcm;
  logic [DCMW-1:0]     p2_dsm;
  logic [CSW-1:0]      p2_csm;
  side_t               p2_side;

  always_ff @(posedge clk) begin
    logic [QB-1:0]      ue;
    logic [QB-1:0]      ug;
    logic [2*QB-1:0]    pm;
    logic signed [37:0] dot;
    logic signed [37:0] dq;
    if (en) begin
      // A zero vector has a zero norm and normalizes to zero.
      for (int i = 0; i < 3; i++) begin
        ue = (dv_ne[QB] == '0) ? '0 : dv_q[QB][i];
        ug = (dv_ng[QB] == '0) ? '0 : dv_q[QB][i+3];
        pm = (2*QB)'(ue) * (2*QB)'(ug);
        p1_prod[i] <= (dv_side[QB].es[i] ^ dv_side[QB].gs[i]) ? -$signed({2'b0, pm})
                                                               : $signed({2'b0, pm});
      end
      p1_dist <= dv_ne[QB][RB-1:4];
      p1_side <= dv_side[QB];

      dot = 38'(p1_prod[0]) + 38'(p1_prod[1]) + 38'(p1_prod[2]);
      dq  = (38'sd1 <<< 32) - dot;
      p2_dir  <= dq[37] ? '0 : dq[35:16];
      p2_dist <= p1_dist;
      p2_dcm  <= DCMW'(p1_dist) * DCMW'(p1_side.cm);
      p2_dsm  <= DCMW'(p1_dist) * DCMW'(p1_side.sm);
      p2_csm  <= CSW'(p1_side.cm) * CSW'(p1_side.sm);
      p2_side <= p1_side;
    end
  end

  // --------------------------------------------------------------------------
  // Term operands, effective weight factors and the split weight multiplies.
  // --------------------------------------------------------------------------
  logic [XW-1:0]       t_x [0:NTERM-1];
  logic [WGT_W-1:0]    t_w [0:NTERM-1];
  logic [FAC_W-1:0]    t_f [0:NTERM-1];
  logic [NTERM-1:0]    t_neg;
  logic [AW-1:0]       ta_a [0:NTERM-1];
  logic [FAC_W-1:0]    ta_f [0:NTERM-1];
  logic [NTERM-1:0]    ta_neg;
  logic [PW-1:0]       tb_lo [0:NTERM-1];
  logic [PW-1:0]       tb_hi [0:NTERM-1];
  logic [NTERM-1:0]    tb_neg;
  logic [BW-1:0]       tc_b [0:NTERM-1];
  logic [NTERM-1:0]    tc_neg;
  logic signed [63:0]  td_t [0:NTERM-1];

  always_ff @(posedge clk) begin
    logic [XW+11:0] dcs_full;
    logic           xs;
    if (en) begin
      dcs_full = (XW+12)'(p2_dcm) * (XW+12)'(p2_side.sm);
      xs       = p2_side.csg ^ p2_side.ssg;

      t_x[T_DIST]   <= XW'(p2_dist);
      t_w[T_DIST]   <= single_weights[15:0];
      t_f[T_DIST]   <= F_UNIT;
      t_neg[T_DIST] <= 1'b0;

      t_x[T_CURV]   <= XW'(p2_side.cm);
      t_w[T_CURV]   <= single_weights[31:16];
      t_f[T_CURV]   <= wgt_one(p2_side.cneg, penalties_first[15:0]);
      t_neg[T_CURV] <= p2_side.csg;

      t_x[T_SULC]   <= XW'(p2_side.sm);
      t_w[T_SULC]   <= single_weights[47:32];
      t_f[T_SULC]   <= wgt_one(p2_side.sneg, penalties_first[31:16]);
      t_neg[T_SULC] <= p2_side.ssg;

      t_x[T_DS]     <= XW'(p2_dsm);
      t_w[T_DS]     <= pair_weights[31:16];
      t_f[T_DS]     <= wgt_one(p2_side.sneg, penalties_first[63:48]);
      t_neg[T_DS]   <= p2_side.ssg;

      t_x[T_DC]     <= XW'(p2_dcm);
      t_w[T_DC]     <= pair_weights[15:0];
      t_f[T_DC]     <= wgt_one(p2_side.cneg, penalties_first[47:32]);
      t_neg[T_DC]   <= p2_side.csg;

      t_x[T_CS]     <= XW'(p2_csm);
      t_w[T_CS]     <= pair_weights[47:32];
      t_f[T_CS]     <= wgt_two(p2_side.cneg, p2_side.sneg, penalties_second[15:0], pp_cs);
      t_neg[T_CS]   <= xs;

      t_x[T_DCS]    <= dcs_full[XW+11:12];
      t_w[T_DCS]    <= pair_weights[63:48];
      t_f[T_DCS]    <= wgt_two(p2_side.cneg, p2_side.sneg, penalties_second[31:16], pp_dcs);
      t_neg[T_DCS]  <= xs;

      t_x[T_DIR]    <= XW'(p2_dir);
      t_w[T_DIR]    <= single_weights[63:48];
      t_f[T_DIR]    <= F_UNIT;
      t_neg[T_DIR]  <= 1'b0;

      ta_neg <= t_neg;
      tb_neg <= ta_neg;
      tc_neg <= tb_neg;
    end
  end

  for (genvar i = 0; i < NTERM; i++) begin : g_term
    logic [BW-1:0] mag;
    assign mag = tc_b[i] >> TERM_SHIFT[i];
    always_ff @(posedge clk) begin
      if (en) begin
        ta_a[i]  <= AW'(t_x[i]) * AW'(t_w[i]);
        ta_f[i]  <= t_f[i];
        tb_lo[i] <= PW'(ta_a[i]) * PW'(ta_f[i][15:0]);
        tb_hi[i] <= PW'(ta_a[i]) * PW'(ta_f[i][31:16]);
        tc_b[i]  <= BW'(tb_lo[i]) + (BW'(tb_hi[i]) << 16);
        // Each term's magnitude stops at the cap before the sign goes on.
        if (mag > BW'(TERM_CAP)) begin
          td_t[i] <= tc_neg[i] ? -$signed(TERM_CAP) : $signed(TERM_CAP);
        end else begin
          td_t[i] <= tc_neg[i] ? -$signed(mag[63:0]) : $signed(mag[63:0]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Accumulator: one term per stage, the sum held within the cap each time.
  // --------------------------------------------------------------------------
  logic signed [63:0] ac_sum [0:NACC-1];
  logic signed [63:0] ac_t   [0:NACC-1][0:NTERM-1];

  for (genvar j = 0; j < NACC; j++) begin : g_acc
    logic signed [63:0] sin;
    logic signed [63:0] tin [0:NTERM-1];
    logic signed [63:0] r;
    if (j == 0) begin : g_first
      assign sin = '0;
      assign tin = td_t;
    end else begin : g_next
      assign sin = ac_sum[j-1];
      assign tin = ac_t[j-1];
    end
    assign r = sin + tin[j];
    always_ff @(posedge clk) begin
      if (en) begin
        if (r > $signed(TERM_CAP)) begin
          ac_sum[j] <= $signed(TERM_CAP);
        end else if (r < -$signed(TERM_CAP)) begin
          ac_sum[j] <= -$signed(TERM_CAP);
        end else begin
          ac_sum[j] <= r;
        end
        ac_t[j] <= tin;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: clamp at zero and at the top of the cost range.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_valid <= 1'b0;
    end else if (!cost_valid || cost_ready) begin
      cost_valid <= ac_v[NACC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!cost_valid || cost_ready) begin
      if (ac_sum[NACC-1] < 0) begin
        edge_cost <= '0;
      end else if (ac_sum[NACC-1] > $signed({1'b0, COST_MAX})) begin
        edge_cost <= COST_MAX[COST_WIDTH-1:0];
      end else begin
        edge_cost <= ac_sum[NACC-1][COST_WIDTH-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A zero-length edge must give a zero unit vector and so a zero dot product.
  a_zero_edge: assert property (@(posedge clk) disable iff (rst)
    (p1_v && p1_dist == '0) |-> (p1_prod[0] == 0 && p1_prod[1] == 0 && p1_prod[2] == 0))
    else $error("zero edge produced a nonzero direction product");

  // An empty output register must never hold off the input.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !cost_valid |-> item_ready)
    else $error("input stalled while the output register was empty");

  // A frozen pipeline keeps its last accumulator stage.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (!en && ac_v[NACC-1]) |=> ($stable(ac_sum[NACC-1]) && ac_v[NACC-1]))
    else $error("last pipeline stage changed during a stall");

endmodule

@@ test/edge_cost_checker.sv @@
// ----------------------------------------------------------------------------
// edge_cost_checker
// Watches the register port and both item channels of the edge cost block.
// It predicts each edge cost from its own copy of the registers and checks
// every result item against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module edge_cost_checker
  import gec_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COST_WIDTH  = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [5:0]                    paddr,
  input  logic [63:0]                   pwdata,
  input  logic                          pready,
  input  logic                          item_valid,
  input  logic                          item_ready,
  input  logic signed [COORD_WIDTH-1:0] from_x,
  input  logic signed [COORD_WIDTH-1:0] from_y,
  input  logic signed [COORD_WIDTH-1:0] from_z,
  input  logic signed [COORD_WIDTH-1:0] to_x,
  input  logic signed [COORD_WIDTH-1:0] to_y,
  input  logic signed [COORD_WIDTH-1:0] to_z,
  input  logic signed [VAL_W-1:0]       curv_value,
  input  logic signed [VAL_W-1:0]       sulc_value,
  input  logic                          cost_valid,
  input  logic                          cost_ready,
  input  logic [COST_WIDTH-1:0]         edge_cost,
  output int                            fails,
  output int                            pending
);

  typedef logic [127:0] wide_t;

  logic [31:0] range_max;
  logic [63:0] single_w;
  logic [63:0] pair_w;
  logic [63:0] pen_first;
  logic [31:0] pen_second;
  logic signed [COORD_WIDTH-1:0] goal_x, goal_y, goal_z;

  logic [COST_WIDTH-1:0] costs_due [$];

  // Integer square root, one bit per pass from the top down.
  function automatic logic [63:0] root_of(input wide_t x);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (wide_t'(c) * wide_t'(c) <= x) r = c;
    end
    return r;
  endfunction

  // Signed product shifted down, magnitude truncated and capped.
  function automatic longint scaled(input longint a, input longint b, input int sh);
    logic [63:0] ma, mb, r;
    wide_t p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (wide_t'(ma) * wide_t'(mb)) >> sh;
    if (p > wide_t'(TERM_CAP)) p = wide_t'(TERM_CAP);
    r = p[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint held_sum(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > longint'(TERM_CAP)) r = longint'(TERM_CAP);
    if (r < -longint'(TERM_CAP)) r = -longint'(TERM_CAP);
    return r;
  endfunction

  function automatic longint unit_part(input longint d, input logic [63:0] n);
    logic [63:0] md, q;
    if (n == 0) return 0;
    md = (d < 0) ? -d : d;
    q = (md << 22) / n;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint factor_one(input logic [15:0] w, input logic neg,
                                        input logic [15:0] p);
    return neg ? ((longint'(w) * longint'(p)) << 8) : (longint'(w) << 16);
  endfunction

  function automatic longint factor_two(input logic [15:0] w, input logic n1,
                                        input logic n2, input logic [15:0] p);
    if (n1 && n2) return longint'(w) * longint'(p) * longint'(p);
    return factor_one(w, n1 || n2, p);
  endfunction

  function automatic logic [COST_WIDTH-1:0] cost_of(
      input longint fx, input longint fy, input longint fz,
      input longint tx, input longint ty, input longint tz,
      input longint cv, input longint sv);
    longint e [3], g [3], ue [3], ug [3];
    logic [63:0] sq_e, sq_g, ne, ng;
    longint elen, dot, dq, dir, c, s, dc, ds, cs, dcs, sum;
    logic cneg, sneg;
    e[0] = tx - fx; e[1] = ty - fy; e[2] = tz - fz;
    g[0] = longint'(goal_x) - fx;
    g[1] = longint'(goal_y) - fy;
    g[2] = longint'(goal_z) - fz;
    sq_e = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
    sq_g = g[0] * g[0] + g[1] * g[1] + g[2] * g[2];
    elen = longint'(root_of(wide_t'(sq_e) << 4));
    ne = root_of(wide_t'(sq_e) << 12);
    ng = root_of(wide_t'(sq_g) << 12);
    for (int i = 0; i < 3; i++) begin
      ue[i] = unit_part(e[i], ne);
      ug[i] = unit_part(g[i], ng);
    end
    dot = ue[0] * ug[0] + ue[1] * ug[1] + ue[2] * ug[2];
    dq = (longint'(1) << 32) - dot;
    if (dq < 0) dq = 0;
    dir = dq >>> 16;
    cneg = cv < 0;
    sneg = sv < 0;
    c = longint'($signed(range_max[15:0])) - cv;
    s = longint'($signed(range_max[31:16])) - sv;
    dc = elen * c;
    ds = elen * s;
    cs = c * s;
    dcs = scaled(dc, s, 12);
    // Accumulate in the same order as the hardware adder chain.
    sum = scaled(longint'(single_w[15:0]) << 16, elen, 24);
    sum = held_sum(sum, scaled(factor_one(single_w[31:16], cneg, pen_first[15:0]), c, 20));
    sum = held_sum(sum, scaled(factor_one(single_w[47:32], sneg, pen_first[31:16]), s, 20));
    sum = held_sum(sum, scaled(factor_one(pair_w[31:16], sneg, pen_first[63:48]), ds, 36));
    sum = held_sum(sum, scaled(factor_one(pair_w[15:0], cneg, pen_first[47:32]), dc, 36));
    sum = held_sum(sum, scaled(factor_two(pair_w[47:32], cneg, sneg, pen_second[15:0]),
                               cs, 32));
    sum = held_sum(sum, scaled(factor_two(pair_w[63:48], cneg, sneg, pen_second[31:16]),
                               dcs, 36));
    sum = held_sum(sum, scaled(longint'(single_w[63:48]) << 16, dir, 24));
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << COST_WIDTH) - 1) return '1;
    return sum[COST_WIDTH-1:0];
  endfunction

  assign pending = costs_due.size();

  always @(posedge clk) begin
    if (rst) begin
      range_max  = RST_RANGE;
      single_w   = RST_SWGT;
      pair_w     = RST_PWGT;
      pen_first  = RST_PEN1;
      pen_second = RST_PEN2;
      goal_x = '0;
      goal_y = '0;
      goal_z = '0;
      costs_due.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_RANGE:  range_max  = pwdata[31:0];
          REG_SWGT:   single_w   = pwdata;
          REG_PWGT:   pair_w     = pwdata;
          REG_PEN1:   pen_first  = pwdata;
          REG_PEN2:   pen_second = pwdata[31:0];
          REG_GOAL_X: goal_x = pwdata[COORD_WIDTH-1:0];
          REG_GOAL_Y: goal_y = pwdata[COORD_WIDTH-1:0];
          REG_GOAL_Z: goal_z = pwdata[COORD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready)
        costs_due.push_back(cost_of(from_x, from_y, from_z, to_x, to_y, to_z,
                                    curv_value, sulc_value));
      if (cost_valid && cost_ready) begin
        if (costs_due.size() == 0) begin
          $display("%0t edge_cost: expected none, actual %0h", $time, edge_cost);
          fails++;
        end else if (costs_due[0] !== edge_cost) begin
          $display("%0t edge_cost: expected %0h, actual %0h", $time, costs_due[0],
                   edge_cost);
          fails++;
          void'(costs_due.pop_front());
        end else begin
          void'(costs_due.pop_front());
        end
      end
    end
  end

endmodule

@@ test/tb_geodesic_edge_cost_top.sv @@
// ----------------------------------------------------------------------------
// tb_geodesic_edge_cost_top
// Stimulus and verdict for the geodesic edge cost block.
// ----------------------------------------------------------------------------
// A short directed set of edges runs first under the reset register values.
// Six random segments follow, each with its own register setting (random,
// all maxima, all zero), with an idle pattern on the two channels per pair
// of segments; the checker beside the block predicts and checks each result.
// ----------------------------------------------------------------------------
module tb_geodesic_edge_cost_top
  import gec_pkg::*;
;

  localparam int CW        = 24;
  localparam int KW        = 48;
  localparam int SETTLE    = 80;    // a little over the pipeline latency
  localparam int STALL_MAX = 3000;  // cycles with no item moving
  localparam int PER_SEG   = 315;

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  logic item_valid, item_ready, cost_valid, cost_ready;
  logic signed [CW-1:0] from_x, from_y, from_z, to_x, to_y, to_z;
  logic signed [VAL_W-1:0] curv_value, sulc_value;
  logic [KW-1:0] edge_cost;
  int fails, pending;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  logic signed [CW-1:0] goal_x, goal_y, goal_z;

  geodesic_edge_cost_top #(.COORD_WIDTH(CW), .COST_WIDTH(KW)) DUT (.*);

  edge_cost_checker #(.COORD_WIDTH(CW), .COST_WIDTH(KW)) u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver drops ready at random, at a rate set per segment.
  always @(posedge clk) begin
    if (rst) begin
      cost_ready <= 1'b0;
    end else begin
      cost_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog ends a hung run: nothing accepted on either channel for
  // far longer than any stall pattern plus the pipeline latency allows.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (cost_valid && cost_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: setup cycle, then access cycle. The caller drops
  // psel once its last write is done.
  task automatic write_reg(input logic [2:0] code, input logic [63:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {code, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (code == REG_GOAL_X) goal_x = value[CW-1:0];
    if (code == REG_GOAL_Y) goal_y = value[CW-1:0];
    if (code == REG_GOAL_Z) goal_z = value[CW-1:0];
  endtask

  // Offer one edge item and hold it until accepted, then idle at random.
  task automatic send_edge(input logic signed [CW-1:0] fx, fy, fz, tx, ty, tz,
                           input logic signed [VAL_W-1:0] cv, sv);
    item_valid <= 1'b1;
    from_x <= fx; from_y <= fy; from_z <= fz;
    to_x   <= tx; to_y   <= ty; to_z   <= tz;
    curv_value <= cv;
    sulc_value <= sv;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Registers may only change with the pipeline empty. The first edge lets
  // the checker count the last item before the queue depth is read.
  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(3))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(8191))) - 16'sd4096;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Most edges are short hops on a mesh; the rest hit zero-length edges,
  // a start on the goal point, full-range extremes and pure noise.
  task automatic random_edge;
    logic signed [CW-1:0] fx, fy, fz, tx, ty, tz;
    fx = CW'($urandom); fy = CW'($urandom); fz = CW'($urandom);
    tx = fx + CW'($signed(18'($urandom)));
    ty = fy + CW'($signed(18'($urandom)));
    tz = fz + CW'($signed(18'($urandom)));
    case ($urandom_range(9))
      0: begin
        tx = CW'($urandom); ty = CW'($urandom); tz = CW'($urandom);
      end
      1: begin
        fx = pick_coord(); fy = pick_coord(); fz = pick_coord();
        tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
      end
      2: begin
        tx = fx; ty = fy; tz = fz;
      end
      3: begin
        fx = goal_x; fy = goal_y; fz = goal_z;
      end
      default: ;
    endcase
    send_edge(fx, fy, fz, tx, ty, tz, pick_value(), pick_value());
  endtask

  // Segment settings: random, then every field at its maximum, then all zero
  // with range maxima most negative, then random, modest weights in segment 4.
  task automatic program_segment(input int seg);
    logic [63:0] sw, pw, p1, p2, rng, gx, gy, gz;
    sw = {$urandom, $urandom}; pw = {$urandom, $urandom};
    p1 = {$urandom, $urandom}; p2 = 64'($urandom); rng = 64'($urandom);
    gx = 64'($urandom); gy = 64'($urandom); gz = 64'($urandom);
    if (seg == 1) begin
      sw = '1; pw = '1; p1 = '1; p2 = 64'(32'hffff_ffff); rng = 64'(32'h7fff_7fff);
      gx = 64'(C_MAX); gy = 64'(C_MAX); gz = 64'(C_MAX);
    end else if (seg == 2) begin
      sw = '0; pw = '0; p1 = '0; p2 = '0; rng = 64'(32'h8000_8000);
      gx = 64'(C_MIN); gy = 64'(C_MIN); gz = 64'(C_MIN);
    end else if (seg == 4) begin
      // Modest weights keep most sums away from the saturation limits.
      sw = {4{8'h00, 8'($urandom)}}; pw = {4{8'h00, 8'($urandom)}};
      p1 = {4{16'h0200}};
    end
    write_reg(REG_RANGE, rng);
    write_reg(REG_SWGT, sw);
    write_reg(REG_PWGT, pw);
    write_reg(REG_PEN1, p1);
    write_reg(REG_PEN2, p2);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_GOAL_Z, gz);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= '0; pwdata <= '0;
    item_valid <= 1'b0;
    from_x <= '0; from_y <= '0; from_z <= '0;
    to_x <= '0; to_y <= '0; to_z <= '0;
    curv_value <= '0; sulc_value <= '0;
    goal_x = '0; goal_y = '0; goal_z = '0;
    send_idle_pct = 22;
    recv_idle_pct = 56;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed edges under the reset registers (goal at the origin).
    send_edge('0, '0, '0, '0, '0, '0, '0, '0);                   // zero edge, zero goal
    send_edge('0, '0, '0, 24'sh004000, '0, '0, '0, '0);          // unit step along x
    send_edge(24'sh004000, '0, '0, '0, '0, '0, '0, '0);          // heading straight home
    send_edge(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '0, '0); // longest edge
    send_edge(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 16'sh7fff, 16'sh7fff);
    send_edge(C_MAX, '0, C_MIN, C_MIN, C_MAX, '0, 16'sh8000, 16'sh8000);
    send_edge('0, '0, '0, 24'sh001000, 24'sh001000, '0, -16'sd1, 16'sd4096);
    send_edge('0, '0, '0, '0, 24'sh002000, '0, 16'sd4096, -16'sd1);
    send_edge('0, '0, '0, '0, '0, 24'sh008000, -16'sd4096, -16'sd4096);
    send_edge(24'sh010000, 24'sh010000, 24'sh010000, 24'sh010001, 24'sh010000,
              24'sh010000, 16'sh8000, 16'sh7fff);
    send_edge(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 16'sh7fff, 16'sh8000);
    send_edge(C_MIN, '0, '0, C_MAX, '0, '0, -16'sd2048, 16'sd0);
    send_edge(24'sh123456, 24'sh6789ab, 24'shcdef01, 24'shedcba9, 24'sh876543,
              24'sh210fed, 16'sh5a5a, 16'sha5a5);
    send_edge(24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555,
              24'shaaaaaa, 16'sh0001, 16'shffff);
    send_edge('0, '0, 24'sh004000, '0, '0, '0, 16'sd0, -16'sd32768);
    send_edge(24'sh000001, '0, '0, '0, '0, '0, 16'sd1, 16'sd1);

    for (int seg = 0; seg < 6; seg++) begin
      drain();
      if (seg < 2) begin
        send_idle_pct = 22; recv_idle_pct = 56;
      end else if (seg < 4) begin
        send_idle_pct = 56; recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      program_segment(seg);
      repeat (PER_SEG) random_edge();
    end

    drain();
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/gec_pkg.sv
hw/rtl/geodesic_edge_cost_top.sv
test/edge_cost_checker.sv
test/tb_geodesic_edge_cost_top.sv
